@@ rtl/cbsu_pkg.sv @@
package cbsu_pkg;

  // Register file geometry: B, C, D, E, H, L, A.
  localparam int unsigned REG_DEPTH = 7;
  localparam int unsigned SLOT_W    = 3;

  typedef logic [SLOT_W-1:0] slot_t;

  // Register file slots that the logic names directly.
  localparam slot_t SLOT_H = 3'd4;
  localparam slot_t SLOT_L = 3'd5;
  localparam slot_t SLOT_A = 3'd6;

  // Command codes.
  localparam logic CMD_EXEC  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Opcode groups in bits 7:6.
  localparam logic [1:0] GRP_SHIFT = 2'd0;
  localparam logic [1:0] GRP_BIT   = 2'd1;
  localparam logic [1:0] GRP_RES   = 2'd2;
  localparam logic [1:0] GRP_SET   = 2'd3;

  // Shift and rotate sub-operations in bits 5:3.
  localparam logic [2:0] SUB_RLC  = 3'd0;
  localparam logic [2:0] SUB_RRC  = 3'd1;
  localparam logic [2:0] SUB_RL   = 3'd2;
  localparam logic [2:0] SUB_RR   = 3'd3;
  localparam logic [2:0] SUB_SLA  = 3'd4;
  localparam logic [2:0] SUB_SRA  = 3'd5;
  localparam logic [2:0] SUB_SWAP = 3'd6;
  localparam logic [2:0] SUB_SRL  = 3'd7;

  // Operand code for the byte at HL, and write target code for the flags.
  localparam logic [2:0] OPND_MEM   = 3'd6;
  localparam logic [2:0] OPND_A     = 3'd7;
  localparam logic [2:0] TSEL_FLAGS = 3'd6;

  // Flag nibble bit positions.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Reported machine cycle counts.
  localparam logic [2:0] CYC_NONE    = 3'd0;
  localparam logic [2:0] CYC_REG     = 3'd2;
  localparam logic [2:0] CYC_BIT_MEM = 3'd3;
  localparam logic [2:0] CYC_MEM     = 3'd4;

  // One write into the register file.
  typedef struct packed {
    logic       we;
    slot_t      addr;
    logic [7:0] data;
  } rf_wr_t;

  // Everything one executed item produces.
  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags;
    rf_wr_t     wr;
    logic       mem_write;
    logic [2:0] cycles;
  } exec_res_t;

  // Operand or target code to register file slot; A sits after L.
  function automatic slot_t slot_of(input logic [2:0] code);
    slot_t s;
    s = (code == OPND_A) ? SLOT_A : code;
    return s;
  endfunction

endpackage

@@ rtl/cbsu_if.sv @@
interface cbsu_in_if;
  import cbsu_pkg::*;

  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] cb_opcode;
  logic [2:0] target_select;
  logic [7:0] write_value;
  logic [7:0] mem_byte;

  modport source (
    output valid, cmd, cb_opcode, target_select, write_value, mem_byte,
    input  ready
  );

  modport sink (
    input  valid, cmd, cb_opcode, target_select, write_value, mem_byte,
    output ready
  );

endinterface

interface cbsu_out_if;
  import cbsu_pkg::*;

  logic        valid;
  logic        ready;
  logic [7:0]  result_value;
  logic [3:0]  flags_out;
  logic        mem_write;
  logic [15:0] hl_address;
  logic [2:0]  machine_cycles;

  modport source (
    output valid, result_value, flags_out, mem_write, hl_address, machine_cycles,
    input  ready
  );

  modport sink (
    input  valid, result_value, flags_out, mem_write, hl_address, machine_cycles,
    output ready
  );

endinterface

@@ rtl/cb_prefix_bit_shift_unit.sv @@
// Each item passes through the execute stage register and then the output register.
// Throughput: one item per cycle while the result side does not stall; the register
// file is read at the input transfer, and a write-back of the item ahead at that same
// edge is bypassed, so dependent items follow directly.
// Reset (synchronous, active low) empties the pipeline and makes every register and
// the flags read as zero at once; no clearing pass is needed.
module cb_prefix_bit_shift_unit
  import cbsu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  cbsu_in_if.sink    in_ch,
  cbsu_out_if.source out_ch
);

  // Execute stage holding registers.
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_opcode_r;
  logic [2:0] s1_tsel_r;
  logic [7:0] s1_wval_r;
  logic [7:0] s1_mbyte_r;

  // Architectural flags and a copy of H and L for the address output.
  logic [3:0] flags_r;
  logic [7:0] h_r;
  logic [7:0] l_r;

  // Output register.
  logic        out_valid_r;
  logic [7:0]  out_result_r;
  logic [3:0]  out_flags_r;
  logic        out_mw_r;
  logic [15:0] out_hl_r;
  logic [2:0]  out_cyc_r;

  logic       in_xfer;
  logic       s1_adv;
  logic [7:0] rf_rd_data;
  logic [7:0] operand;
  exec_res_t  exec_res;
  rf_wr_t     rf_wr;
  logic [7:0] h_nxt;
  logic [7:0] l_nxt;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  cbsu_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (slot_of(in_ch.cb_opcode[2:0])),
    .rd_data (rf_rd_data),
    .wr      (rf_wr)
  );

  assign operand = (s1_opcode_r[2:0] == OPND_MEM) ? s1_mbyte_r : rf_rd_data;

  cbsu_alu u_alu (
    .cmd           (s1_cmd_r),
    .cb_opcode     (s1_opcode_r),
    .target_select (s1_tsel_r),
    .write_value   (s1_wval_r),
    .operand       (operand),
    .flags_in      (flags_r),
    .res           (exec_res)
  );

  // Write-back commits only when the item leaves the execute stage.
  always_comb begin
    rf_wr    = exec_res.wr;
    rf_wr.we = exec_res.wr.we && s1_adv;
  end

  // H and L as they stand after this item.
  assign h_nxt = (rf_wr.we && rf_wr.addr == SLOT_H) ? rf_wr.data : h_r;
  assign l_nxt = (rf_wr.we && rf_wr.addr == SLOT_L) ? rf_wr.data : l_r;

  // Execute stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // Execute stage payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r    <= in_ch.cmd;
      s1_opcode_r <= in_ch.cb_opcode;
      s1_tsel_r   <= in_ch.target_select;
      s1_wval_r   <= in_ch.write_value;
      s1_mbyte_r  <= in_ch.mem_byte;
    end
  end

  // Flags and the H/L copy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      h_r     <= '0;
      l_r     <= '0;
    end else if (s1_adv) begin
      flags_r <= exec_res.flags;
      h_r     <= h_nxt;
      l_r     <= l_nxt;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_result_r <= exec_res.result;
      out_flags_r  <= exec_res.flags;
      out_mw_r     <= exec_res.mem_write;
      out_hl_r     <= {h_nxt, l_nxt};
      out_cyc_r    <= exec_res.cycles;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_value   = out_result_r;
  assign out_ch.flags_out      = out_flags_r;
  assign out_ch.mem_write      = out_mw_r;
  assign out_ch.hl_address     = out_hl_r;
  assign out_ch.machine_cycles = out_cyc_r;

  // A memory write-back is always reported with the CYC_MEM cycle count.
  a_mw_cycles : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mw_r) |-> (out_cyc_r == CYC_MEM))
    else $error("memory write-back with wrong cycle count");

  // A stalled execute stage never touches the register file.
  a_stall_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !rf_wr.we)
    else $error("register write while execute stage is stalled");

  // A stalled item stays in the execute stage with its opcode intact.
  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_opcode_r)))
    else $error("stalled item lost from execute stage");

  // Reset leaves both stages empty.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

endmodule

@@ rtl/cbsu_regfile.sv @@
module cbsu_regfile
  import cbsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rd_en,
  input  slot_t      rd_addr,
  output logic [7:0] rd_data,
  input  rf_wr_t     wr
);

  logic [7:0]           mem [REG_DEPTH];
  logic [REG_DEPTH-1:0] vld_r;
  logic [7:0]           rd_q_r;
  logic                 byp_hit_r;
  logic [7:0]           byp_data_r;

  // Storage array; one write port.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Entries that were never written read as zero after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.we) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Registered read; a write to the same entry at the same edge is bypassed.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= vld_r[rd_addr] ? mem[rd_addr] : 8'h00;
      byp_hit_r  <= wr.we && (wr.addr == rd_addr);
      byp_data_r <= wr.data;
    end
  end

  assign rd_data = byp_hit_r ? byp_data_r : rd_q_r;

endmodule

@@ rtl/cbsu_alu.sv @@
module cbsu_alu
  import cbsu_pkg::*;
(
  input  logic       cmd,
  input  logic [7:0] cb_opcode,
  input  logic [2:0] target_select,
  input  logic [7:0] write_value,
  input  logic [7:0] operand,
  input  logic [3:0] flags_in,
  output exec_res_t  res
);

  logic [1:0] group;
  logic [2:0] sub;
  logic [2:0] code;
  logic       is_mem;
  logic [7:0] bit_mask;
  logic [7:0] shift_val;
  logic       shift_c;
  logic       cin;

  assign group    = cb_opcode[7:6];
  assign sub      = cb_opcode[5:3];
  assign code     = cb_opcode[2:0];
  assign is_mem   = (code == OPND_MEM);
  assign bit_mask = 8'h01 << sub;
  assign cin      = flags_in[FLAG_C];

  // Shift and rotate group.
  always_comb begin
    case (sub)
      SUB_RLC:  begin shift_c = operand[7]; shift_val = {operand[6:0], operand[7]}; end
      SUB_RRC:  begin shift_c = operand[0]; shift_val = {operand[0], operand[7:1]}; end
      SUB_RL:   begin shift_c = operand[7]; shift_val = {operand[6:0], cin}; end
      SUB_RR:   begin shift_c = operand[0]; shift_val = {cin, operand[7:1]}; end
      SUB_SLA:  begin shift_c = operand[7]; shift_val = {operand[6:0], 1'b0}; end
      SUB_SRA:  begin shift_c = operand[0]; shift_val = {operand[7], operand[7:1]}; end
      SUB_SWAP: begin shift_c = 1'b0;       shift_val = {operand[3:0], operand[7:4]}; end
      default:  begin shift_c = operand[0]; shift_val = {1'b0, operand[7:1]}; end
    endcase
  end

  // Result, flags and write-back decision.
  always_comb begin
    res           = '0;
    res.flags     = flags_in;
    res.cycles    = CYC_NONE;
    res.wr.addr   = slot_of(code);
    if (cmd == CMD_WRITE) begin
      res.wr.addr = slot_of(target_select);
      if (target_select == TSEL_FLAGS) begin
        res.flags  = write_value[3:0];
        res.result = {4'h0, write_value[3:0]};
      end else begin
        res.wr.we  = 1'b1;
        res.result = write_value;
      end
      res.wr.data = write_value;
    end else begin
      unique case (group)
        GRP_SHIFT: begin
          res.result = shift_val;
          res.flags  = '0;
          res.flags[FLAG_Z] = (shift_val == 8'h00);
          res.flags[FLAG_C] = shift_c;
        end
        GRP_BIT: begin
          res.result = operand;
          res.flags[FLAG_Z] = ~|(operand & bit_mask);
          res.flags[FLAG_N] = 1'b0;
          res.flags[FLAG_H] = 1'b1;
        end
        GRP_RES: res.result = operand & ~bit_mask;
        GRP_SET: res.result = operand | bit_mask;
      endcase
      res.wr.data = res.result;
      if (group == GRP_BIT) begin
        res.cycles = is_mem ? CYC_BIT_MEM : CYC_REG;
      end else if (is_mem) begin
        res.mem_write = 1'b1;
        res.cycles    = CYC_MEM;
      end else begin
        res.wr.we  = 1'b1;
        res.cycles = CYC_REG;
      end
    end
  end

endmodule

@@ test/cbsu_result_checker.sv @@
module cbsu_result_checker
  import cbsu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cbsu_in_if   in_mon,
  cbsu_out_if  out_mon,
  output int   fail_count,
  output int   pending_count
);

  // One outcome of a CB step, laid out like the result channel.
  typedef struct packed {
    logic [7:0]  value;
    logic [3:0]  flags;
    logic        mem_wr;
    logic [15:0] hl;
    logic [2:0]  cycles;
  } cb_outcome_t;

  // Mirror of the block's register file and flag nibble.
  logic [7:0] shadow_regs [REG_DEPTH];
  logic [3:0] shadow_flags;

  cb_outcome_t outcome_fifo [$];
  int          errors = 0;

  // Operand or write target code to a register file slot; A follows L.
  function automatic slot_t rf_index(input logic [2:0] code);
    if (code == OPND_A) begin
      return SLOT_A;
    end
    return slot_t'(code);
  endfunction

  // Applies one accepted item to the mirror and returns what the block must report.
  task automatic run_cb_step(input logic cmd, input logic [7:0] opcode,
                             input logic [2:0] tsel, input logic [7:0] wval,
                             input logic [7:0] mbyte, output cb_outcome_t res);
    logic [1:0] grp;
    logic [2:0] sub;
    logic [2:0] code;
    logic       is_mem;
    logic [7:0] v;
    logic [7:0] nv;
    logic       c;
    logic       cin;

    grp    = opcode[7:6];
    sub    = opcode[5:3];
    code   = opcode[2:0];
    is_mem = (code == OPND_MEM);
    res    = '0;

    if (cmd == CMD_WRITE) begin
      // Register or flag load; the flags keep only the low nibble.
      if (tsel == TSEL_FLAGS) begin
        shadow_flags = wval[3:0];
        res.value    = {4'h0, shadow_flags};
      end else begin
        shadow_regs[rf_index(tsel)] = wval;
        res.value                   = wval;
      end
      res.cycles = CYC_NONE;
    end else begin
      v = is_mem ? mbyte : shadow_regs[rf_index(code)];
      if (grp == GRP_BIT) begin
        // BIT tests one bit, sets H, clears N and keeps C; nothing is written.
        c                    = shadow_flags[FLAG_C];
        shadow_flags         = '0;
        shadow_flags[FLAG_Z] = ~v[sub];
        shadow_flags[FLAG_H] = 1'b1;
        shadow_flags[FLAG_C] = c;
        res.value            = v;
        res.cycles           = is_mem ? CYC_BIT_MEM : CYC_REG;
      end else begin
        if (grp == GRP_SHIFT) begin
          cin = shadow_flags[FLAG_C];
          case (sub)
            SUB_RLC: begin
              c  = v[7];
              nv = {v[6:0], v[7]};
            end
            SUB_RRC: begin
              c  = v[0];
              nv = {v[0], v[7:1]};
            end
            SUB_RL: begin
              c  = v[7];
              nv = {v[6:0], cin};
            end
            SUB_RR: begin
              c  = v[0];
              nv = {cin, v[7:1]};
            end
            SUB_SLA: begin
              c  = v[7];
              nv = {v[6:0], 1'b0};
            end
            SUB_SRA: begin
              c  = v[0];
              nv = {v[7], v[7:1]};
            end
            SUB_SWAP: begin
              c  = 1'b0;
              nv = {v[3:0], v[7:4]};
            end
            default: begin
              c  = v[0];
              nv = {1'b0, v[7:1]};
            end
          endcase
          shadow_flags         = '0;
          shadow_flags[FLAG_Z] = (nv == 8'h00);
          shadow_flags[FLAG_C] = c;
        end else if (grp == GRP_RES) begin
          nv = v & ~(8'h01 << sub);
        end else begin
          nv = v | (8'h01 << sub);
        end
        res.value = nv;
        // A memory operand goes back out as a write; a register is updated in place.
        if (is_mem) begin
          res.mem_wr = 1'b1;
          res.cycles = CYC_MEM;
        end else begin
          shadow_regs[rf_index(code)] = nv;
          res.cycles                  = CYC_REG;
        end
      end
    end
    res.flags = shadow_flags;
    res.hl    = {shadow_regs[SLOT_H], shadow_regs[SLOT_L]};
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Compare each result transfer with the oldest outcome, then record new input transfers.
  always @(posedge clk) begin
    cb_outcome_t want_o;
    cb_outcome_t next_o;

    if (!rst_n) begin
      for (int i = 0; i < REG_DEPTH; i++) begin
        shadow_regs[i] = 8'h00;
      end
      shadow_flags = 4'h0;
      outcome_fifo.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (outcome_fifo.size() == 0) begin
          $error("result transfer with no outcome waiting: value 0x%0h",
                 out_mon.result_value);
          errors++;
        end else begin
          want_o = outcome_fifo.pop_front();
          check_field("result_value", 16'(want_o.value), 16'(out_mon.result_value));
          check_field("flags_out", 16'(want_o.flags), 16'(out_mon.flags_out));
          check_field("mem_write", 16'(want_o.mem_wr), 16'(out_mon.mem_write));
          check_field("hl_address", want_o.hl, out_mon.hl_address);
          check_field("machine_cycles", 16'(want_o.cycles), 16'(out_mon.machine_cycles));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        run_cb_step(in_mon.cmd, in_mon.cb_opcode, in_mon.target_select,
                    in_mon.write_value, in_mon.mem_byte, next_o);
        outcome_fifo.push_back(next_o);
      end
    end
    fail_count    <= errors;
    pending_count <= outcome_fifo.size();
  end

endmodule

@@ test/testbench.sv @@
module testbench;
  import cbsu_pkg::*;

  // Register operand and write target codes not named in the package.
  localparam logic [2:0] CODE_B = 3'd0;
  localparam logic [2:0] CODE_C = 3'd1;
  localparam logic [2:0] CODE_D = 3'd2;
  localparam logic [2:0] CODE_E = 3'd3;
  localparam logic [2:0] CODE_H = 3'd4;
  localparam logic [2:0] CODE_L = 3'd5;

  localparam int LONG_HOLD   = 300;
  localparam int CHUNK_ITEMS = 25;
  localparam int CHUNKS      = 57;

  logic clk;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_count;
  int   hold_requests = 0;
  int   hold_served   = 0;

  cbsu_in_if  in_ch ();
  cbsu_out_if out_ch ();

  cb_prefix_bit_shift_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cbsu_result_checker check_u (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length: mostly none, sometimes a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] cb_op(input logic [1:0] grp, input logic [2:0] sub,
                                       input logic [2:0] code);
    return {grp, sub, code};
  endfunction

  // Offer one item from a falling edge, hold it until its transfer, then idle for the gap, if any.
  task automatic send_item(input logic cmd, input logic [7:0] opcode,
                           input logic [2:0] tsel, input logic [7:0] wval,
                           input logic [7:0] mbyte, input int gap);
    in_ch.cmd           = cmd;
    in_ch.cb_opcode     = opcode;
    in_ch.target_select = tsel;
    in_ch.write_value   = wval;
    in_ch.mem_byte      = mbyte;
    in_ch.valid         = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_write(input logic [2:0] tsel, input logic [7:0] wval);
    send_item(CMD_WRITE, 8'($urandom), tsel, wval, 8'($urandom), pick_gap());
  endtask

  task automatic send_exec(input logic [7:0] opcode, input logic [7:0] mbyte);
    send_item(CMD_EXEC, opcode, 3'($urandom), 8'($urandom), mbyte, pick_gap());
  endtask

  task automatic send_random_item(input int gap);
    logic       cmd;
    logic [7:0] mbyte;
    int         r;
    cmd = ($urandom_range(0, 99) < 15) ? CMD_WRITE : CMD_EXEC;
    r   = $urandom_range(0, 19);
    case (r)
      0:       mbyte = 8'h00;
      1:       mbyte = 8'hFF;
      2:       mbyte = 8'h80;
      3:       mbyte = 8'h01;
      default: mbyte = 8'($urandom);
    endcase
    send_item(cmd, 8'($urandom), 3'($urandom), 8'($urandom), mbyte, gap);
  endtask

  // Stop offering and wait at falling edges until every outcome has been seen.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Result side: random stalls, calm stretches, and long hold-offs on request.
  initial begin : receiver
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_served != hold_requests) begin
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_served++;
      end else if ($urandom_range(0, 9) < 2) begin
        out_ch.ready = 1'b1;
        repeat (40) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // Stimulus: reset, directed items, then random chunks with pressure phases.
  initial begin : stimulus
    bit calm;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_EXEC;
    in_ch.cb_opcode     = 8'h00;
    in_ch.target_select = 3'd0;
    in_ch.write_value   = 8'h00;
    in_ch.mem_byte      = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Load every register, B to E with extremes, and the flags with a full byte.
    send_write(CODE_B, 8'hFF);
    send_write(CODE_C, 8'h80);
    send_write(CODE_D, 8'h01);
    send_write(CODE_E, 8'h00);
    send_write(CODE_H, 8'hAB);
    send_write(CODE_L, 8'hCD);
    send_write(OPND_A, 8'h7F);
    send_write(TSEL_FLAGS, 8'hFF);

    // Each shift and rotate, rotates through a set carry, H and L operands.
    send_exec(cb_op(GRP_SHIFT, SUB_RL, CODE_B), 8'($urandom));
    send_exec(cb_op(GRP_SHIFT, SUB_RR, CODE_C), 8'($urandom));
    send_exec(cb_op(GRP_SHIFT, SUB_RLC, CODE_D), 8'($urandom));
    send_exec(cb_op(GRP_SHIFT, SUB_RRC, CODE_E), 8'($urandom));
    send_exec(cb_op(GRP_SHIFT, SUB_SLA, CODE_H), 8'($urandom));
    send_exec(cb_op(GRP_SHIFT, SUB_SRA, CODE_L), 8'($urandom));
    send_exec(cb_op(GRP_SHIFT, SUB_SWAP, OPND_A), 8'($urandom));
    send_exec(cb_op(GRP_SHIFT, SUB_SRL, OPND_MEM), 8'h01);
    send_exec(cb_op(GRP_SHIFT, SUB_RLC, OPND_MEM), 8'hFF);

    // BIT keeps the carry and never writes back; RES and SET leave the flags.
    send_exec(cb_op(GRP_BIT, 3'd7, OPND_A), 8'($urandom));
    send_exec(cb_op(GRP_BIT, 3'd0, OPND_MEM), 8'h00);
    send_exec(cb_op(GRP_RES, 3'd7, OPND_MEM), 8'hFF);
    send_exec(cb_op(GRP_SET, 3'd0, CODE_B), 8'($urandom));
    send_exec(cb_op(GRP_RES, 3'd3, CODE_L), 8'($urandom));
    send_exec(cb_op(GRP_SET, 3'd7, CODE_H), 8'($urandom));
    send_write(TSEL_FLAGS, 8'h00);
    send_exec(cb_op(GRP_SHIFT, SUB_SWAP, OPND_MEM), 8'h00);

    drain();

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      calm = ($urandom_range(0, 3) == 0);
      // Long receiver hold-off while the sender keeps offering back to back.
      if (chunk == 12 || chunk == 40) begin
        hold_requests++;
        calm = 1'b1;
      end
      if (chunk == 28) begin
        drain();
      end
      for (int k = 0; k < CHUNK_ITEMS; k++) begin
        send_random_item(calm ? 0 : pick_gap());
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("status: fail");
    $finish;
  end

endmodule
